FILE: sv/fpconv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpconv_pkg
// Shared types and constants for the fp16 / bf16 / fp32 format converter.
// ----------------------------------------------------------------------------
package fpconv_pkg;

    // operation codes
    localparam logic [1:0] OP_H2F = 2'd0;  // fp16 -> fp32
    localparam logic [1:0] OP_B2F = 2'd1;  // bf16 -> fp32
    localparam logic [1:0] OP_F2H = 2'd2;  // fp32 -> fp16
    localparam logic [1:0] OP_F2B = 2'd3;  // fp32 -> bf16

    // format constants
    localparam logic [7:0]  F32_EXP_ALL = 8'hFF;
    localparam logic [4:0]  H_EXP_ALL   = 5'h1F;
    localparam logic [15:0] H_INF       = 16'h7C00;
    localparam logic [15:0] H_QNAN_BIT  = 16'h0200;
    localparam logic [15:0] BF_INF      = 16'h7F80;
    localparam logic [15:0] BF_QNAN_BIT = 16'h0040;

    // fp32 exponent bias minus fp16 exponent bias
    localparam logic [7:0]  H_BIAS_DIFF = 8'd112;

    // input word
    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] value_in;
    } req_t;

    // result word
    typedef struct packed {
        logic [31:0] value_out;
        logic        not_finite;
    } rsp_t;

endpackage

FILE: sv/fp16_bf16_fp32_converter.sv
`timescale 1ns / 1ps
// Path: an accepted input word passes the input register, then the result register.
// Throughput: one word per cycle; the input register and the result register
// advance together, so the input stalls only while a result sits stalled and
// the input register is full.
// Reset: rst_n clears both valid flags; the data registers are not reset.
// ----------------------------------------------------------------------------
// fp16_bf16_fp32_converter
// Converts between fp16, bf16 and fp32, one word per clock while results are not stalled.
// ----------------------------------------------------------------------------
module fp16_bf16_fp32_converter
    import fpconv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic in_valid_reg;
    req_t in_reg;
    logic out_valid_reg;
    rsp_t out_reg;
    logic out_move;
    rsp_t widen_rsp;
    rsp_t narrow_rsp;
    rsp_t out_next;

    // handshake
    assign out_move  = !out_valid_reg || !rsp_stall;
    assign req_stall = in_valid_reg && !out_move;

    // input register, fills whenever the input side is not stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall && req_valid)
        begin
            in_reg <= req;
        end
    end

    // conversion units
    fpconv_widen u_widen
    (
        .req (in_reg),
        .rsp (widen_rsp)
    );

    fpconv_narrow u_narrow
    (
        .req (in_reg),
        .rsp (narrow_rsp)
    );

    assign out_next = (in_reg.req_type == OP_H2F || in_reg.req_type == OP_B2F)
                      ? widen_rsp : narrow_rsp;

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_move)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_move && in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

FILE: sv/fpconv_widen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpconv_widen
// Widens fp16 or bf16 to fp32; fp16 subnormals are normalized exactly.
// ----------------------------------------------------------------------------
module fpconv_widen
    import fpconv_pkg::*;
(
    input  req_t req,
    output rsp_t rsp
);

    logic        h_sign;
    logic [4:0]  h_exp;
    logic [9:0]  h_frac;
    logic [3:0]  msb;
    logic [3:0]  norm_sh;
    logic [9:0]  norm_frac;
    logic [7:0]  norm_exp;
    logic [31:0] h_res;
    logic [31:0] b_res;

    assign h_sign = req.value_in[15];
    assign h_exp  = req.value_in[14:10];
    assign h_frac = req.value_in[9:0];

    // leading one of the subnormal fraction
    always_comb
    begin
        msb = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (h_frac[i])
            begin
                msb = 4'(i);
            end
        end
    end

    // normalize: shift the leading one out past bit 9
    assign norm_sh   = 4'd10 - msb;
    assign norm_frac = h_frac << norm_sh;
    assign norm_exp  = 8'd103 + {4'b0000, msb};

    // fp16 -> fp32
    always_comb
    begin
        if (h_exp == 5'd0)
        begin
            if (h_frac == 10'd0)
            begin
                h_res = {h_sign, 31'd0};
            end
            else
            begin
                h_res = {h_sign, norm_exp, norm_frac, 13'd0};
            end
        end
        else if (h_exp == H_EXP_ALL)
        begin
            h_res = {h_sign, F32_EXP_ALL, h_frac, 13'd0};
        end
        else
        begin
            h_res = {h_sign, {3'b000, h_exp} + H_BIAS_DIFF, h_frac, 13'd0};
        end
    end

    // bf16 -> fp32
    assign b_res = {req.value_in[15:0], 16'd0};

    // select by operation
    always_comb
    begin
        if (req.req_type == OP_B2F)
        begin
            rsp.value_out  = b_res;
            rsp.not_finite = (req.value_in[15:0] & BF_INF) == BF_INF;
        end
        else
        begin
            rsp.value_out  = h_res;
            rsp.not_finite = h_exp == H_EXP_ALL;
        end
    end

endmodule

FILE: sv/fpconv_narrow.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpconv_narrow
// Narrows fp32 to fp16 or bf16 with round to nearest, ties to even.
// ----------------------------------------------------------------------------
module fpconv_narrow
    import fpconv_pkg::*;
(
    input  req_t req,
    output rsp_t rsp
);

    logic        sign;
    logic [7:0]  f_exp;
    logic [22:0] f_frac;
    logic [4:0]  sub_sh;
    logic [24:0] man;
    logic [24:0] man_shr;
    logic [24:0] sub_bias;
    logic [24:0] sub_rnd;
    logic [24:0] sub_out;
    logic [23:0] nrm_rnd;
    logic [4:0]  he;
    logic [15:0] h_res;
    logic [31:0] b_sum;
    logic [15:0] b_res;
    logic        src_nf;

    assign sign   = req.value_in[31];
    assign f_exp  = req.value_in[30:23];
    assign f_frac = req.value_in[22:0];
    assign src_nf = f_exp == F32_EXP_ALL;

    // subnormal fp16 path, shift of 14..24
    assign sub_sh   = 5'(8'd126 - f_exp);
    assign man      = {2'b01, f_frac};
    assign man_shr  = man >> sub_sh;
    assign sub_bias = (25'd1 << (sub_sh - 5'd1)) - 25'd1;
    assign sub_rnd  = man + sub_bias + {24'd0, man_shr[0]};
    assign sub_out  = sub_rnd >> sub_sh;

    // normal fp16 path
    assign nrm_rnd = {1'b0, f_frac} + 24'h000FFF + {23'd0, f_frac[13]};
    assign he      = 5'(f_exp - H_BIAS_DIFF);

    // fp32 -> fp16
    always_comb
    begin
        if (src_nf)
        begin
            h_res = {sign, 15'd0} | H_INF | ((f_frac != 23'd0) ? H_QNAN_BIT : 16'd0);
        end
        else if (f_exp >= 8'd143)
        begin
            h_res = {sign, 15'd0} | H_INF;
        end
        else if (f_exp < 8'd102)
        begin
            h_res = {sign, 15'd0};
        end
        else if (f_exp <= H_BIAS_DIFF)
        begin
            h_res = {sign, 4'd0, sub_out[10:0]};
        end
        else if (nrm_rnd[23])
        begin
            h_res = {sign, he + 5'd1, 10'd0};
        end
        else
        begin
            h_res = {sign, he, nrm_rnd[22:13]};
        end
    end

    // fp32 -> bf16
    assign b_sum = req.value_in + 32'h0000_7FFF + {31'd0, req.value_in[16]};

    always_comb
    begin
        if (src_nf && (f_frac != 23'd0))
        begin
            b_res = req.value_in[31:16] | BF_QNAN_BIT;
        end
        else
        begin
            b_res = b_sum[31:16];
        end
    end

    // select by operation
    always_comb
    begin
        if (req.req_type == OP_F2B)
        begin
            rsp.value_out  = {16'd0, b_res};
            rsp.not_finite = src_nf || ((b_res & BF_INF) == BF_INF);
        end
        else
        begin
            rsp.value_out  = {16'd0, h_res};
            rsp.not_finite = src_nf || ((h_res & H_INF) == H_INF);
        end
    end

endmodule

FILE: sv/fpconv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpconv_checker
// Port-level checks for the format converter, bound to the top level.
// ----------------------------------------------------------------------------
module fpconv_checker
    import fpconv_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // input stalls only behind a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
    else $error("input stalled while result side is free");

    // a new result word follows an accepted input word through both registers
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
    else $error("result word without matching input word");

    // stalled result word stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> rsp_valid)
    else $error("result word dropped while stalled");

    // stalled result word holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> $stable(rsp))
    else $error("result payload changed while stalled");

endmodule

bind fp16_bf16_fp32_converter fpconv_checker u_chk (.*);

FILE: test/fp16_bf16_fp32_converter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp16_bf16_fp32_converter_tb
// Self-checking bench for the fp16 / bf16 / fp32 converter. A directed table
// covers format extremes, NaN and infinity handling and rounding ties; random
// words follow under several sender idle and receiver stall mixes. Every
// result word is checked against its typed answer from the table or against a conversion function kept in this bench.
// ----------------------------------------------------------------------------
module fp16_bf16_fp32_converter_tb;
    import fpconv_pkg::*;

    localparam int NUM_DIRECTED  = 25;
    localparam int RANDOM_PER_MIX = 85;
    localparam int HOLD_CYCLES   = 40;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;

    // one row of the directed table; typed rows carry their own answer
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] bits;
        logic        typed;
        logic [31:0] typed_out;
        logic        typed_nf;
    } vector_row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    rsp_t pending_results [$];
    rsp_t oldest_result;
    int   error_count = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    logic hold_request;

    int   mix_idle  [4] = '{0, 70, 0, 18};
    int   mix_stall [4] = '{0, 0, 70, 18};

    vector_row_t directed_vectors [NUM_DIRECTED] = '{
        '{OP_H2F, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_H2F, 32'hFFFF_8000, 1'b1, 32'h8000_0000, 1'b0},
        '{OP_H2F, 32'h0000_7C00, 1'b1, 32'h7F80_0000, 1'b1},
        '{OP_H2F, 32'h0000_FC01, 1'b1, 32'hFF80_2000, 1'b1},
        '{OP_H2F, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
        '{OP_H2F, 32'h0000_83FF, 1'b0, 32'h0, 1'b0},
        '{OP_H2F, 32'h0000_7BFF, 1'b0, 32'h0, 1'b0},
        '{OP_B2F, 32'hABCD_7F80, 1'b1, 32'h7F80_0000, 1'b1},
        '{OP_B2F, 32'h0000_FFFF, 1'b1, 32'hFFFF_0000, 1'b1},
        '{OP_B2F, 32'hFFFF_0001, 1'b1, 32'h0001_0000, 1'b0},
        '{OP_F2H, 32'h7F80_0000, 1'b1, 32'h0000_7C00, 1'b1},
        '{OP_F2H, 32'hFF80_0001, 1'b1, 32'h0000_FE00, 1'b1},
        '{OP_F2H, 32'h7FFF_FFFF, 1'b1, 32'h0000_7E00, 1'b1},
        '{OP_F2H, 32'h4780_0000, 1'b1, 32'h0000_7C00, 1'b1},
        '{OP_F2H, 32'h477F_F000, 1'b0, 32'h0, 1'b0},
        '{OP_F2H, 32'h477F_EFFF, 1'b0, 32'h0, 1'b0},
        '{OP_F2H, 32'h0000_0001, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_F2H, 32'h8000_0000, 1'b1, 32'h0000_8000, 1'b0},
        '{OP_F2H, 32'h3300_0000, 1'b0, 32'h0, 1'b0},
        '{OP_F2H, 32'h387F_E000, 1'b0, 32'h0, 1'b0},
        '{OP_F2H, 32'h3F80_1000, 1'b0, 32'h0, 1'b0},
        '{OP_F2B, 32'h7F80_0001, 1'b1, 32'h0000_7FC0, 1'b1},
        '{OP_F2B, 32'hFFFF_FFFF, 1'b1, 32'h0000_FFFF, 1'b1},
        '{OP_F2B, 32'h7F7F_FFFF, 1'b0, 32'h0, 1'b0},
        '{OP_F2B, 32'h3F80_8000, 1'b0, 32'h0, 1'b0}
    };

    fp16_bf16_fp32_converter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // fp16 -> fp32, exact
    function automatic logic [31:0] widen_fp16(input logic [15:0] h);
        logic [7:0]  e;
        logic [10:0] m;
        if (h[14:10] == 5'd0)
        begin
            if (h[9:0] == 10'd0)
                return {h[15], 31'd0};
            // normalize the subnormal
            e = 8'd113;
            m = {1'b0, h[9:0]};
            while (!m[10])
            begin
                m = m << 1;
                e = e - 8'd1;
            end
            return {h[15], e, m[9:0], 13'd0};
        end
        if (h[14:10] == H_EXP_ALL)
            return {h[15], F32_EXP_ALL, h[9:0], 13'd0};
        return {h[15], 8'(h[14:10]) + H_BIAS_DIFF, h[9:0], 13'd0};
    endfunction

    // fp32 -> fp16, round to nearest even
    function automatic logic [15:0] narrow_to_fp16(input logic [31:0] v);
        logic [15:0] s;
        logic [31:0] fr;
        logic [31:0] man;
        logic [31:0] rnd;
        int          ex;
        int          he;
        int          sh;
        s  = {v[31], 15'd0};
        fr = {9'd0, v[22:0]};
        ex = v[30:23];
        if (v[30:23] == F32_EXP_ALL)
            return s | H_INF | ((fr != 32'd0) ? H_QNAN_BIT : 16'h0000);
        he = ex - 112;
        if (he >= 31)
            return s | H_INF;
        // subnormal range, or flush to signed zero below it
        if (he <= 0)
        begin
            if (he < -10)
                return s;
            man = fr | 32'h0080_0000;
            sh  = 14 - he;
            rnd = man + ((32'd1 << (sh - 1)) - 32'd1) + ((man >> sh) & 32'd1);
            return s | 16'(rnd >> sh);
        end
        rnd = fr + 32'h0000_0FFF + ((fr >> 13) & 32'd1);
        // mantissa carry bumps the exponent, possibly into infinity
        if (rnd[23])
            return s | 16'((he + 1) << 10);
        return s | 16'(he << 10) | 16'(rnd >> 13);
    endfunction

    // fp32 -> bf16, round to nearest even, quiet NaN
    function automatic logic [15:0] narrow_to_bf16(input logic [31:0] v);
        logic [31:0] rnd;
        if (v[30:23] == F32_EXP_ALL && v[22:0] != 23'd0)
            return v[31:16] | BF_QNAN_BIT;
        rnd = v + 32'h0000_7FFF + {31'd0, v[16]};
        return rnd[31:16];
    endfunction

    // expected result word for one input word
    function automatic rsp_t convert_word(input req_t w);
        rsp_t        r;
        logic [15:0] h;
        logic [31:0] v;
        v = w.value_in;
        case (w.req_type)
            OP_H2F:
            begin
                r.value_out  = widen_fp16(v[15:0]);
                r.not_finite = (v[14:10] == H_EXP_ALL);
            end
            OP_B2F:
            begin
                r.value_out  = {v[15:0], 16'd0};
                r.not_finite = ((v[15:0] & BF_INF) == BF_INF);
            end
            OP_F2H:
            begin
                h = narrow_to_fp16(v);
                r.value_out  = {16'd0, h};
                r.not_finite = (v[30:23] == F32_EXP_ALL) || ((h & H_INF) == H_INF);
            end
            default:
            begin
                h = narrow_to_bf16(v);
                r.value_out  = {16'd0, h};
                r.not_finite = (v[30:23] == F32_EXP_ALL) || ((h & BF_INF) == BF_INF);
            end
        endcase
        return r;
    endfunction

    // random word, biased toward range edges, specials and rounding ties
    function automatic req_t random_word();
        req_t        w;
        logic [15:0] ties [5] = '{16'h8000, 16'h7FFF, 16'h1000, 16'h3000, 16'h0FFF};
        w.req_type = 2'($urandom_range(0, 3));
        w.value_in = $urandom();
        case ($urandom_range(0, 7))
            0, 1: ;
            2, 3: w.value_in[30:23] = 8'($urandom_range(98, 145));
            4: w.value_in[30:23] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            5:
            begin
                w.value_in[30:23] = 8'($urandom_range(98, 145));
                w.value_in[15:0]  = ties[$urandom_range(0, 4)];
            end
            6:
            begin
                if ($urandom_range(0, 1) != 0)
                    w.value_in[14:10] = ($urandom_range(0, 1) != 0) ? 5'h1F : 5'h00;
                else
                    w.value_in[14:7] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            end
            default:
            begin
                // largest fp16 binade, rounding may carry into infinity
                w.value_in[30:23] = 8'h8E;
                w.value_in[22:13] = 10'h3FF;
            end
        endcase
        return w;
    endfunction

    // offer one word, with random idle cycles ahead of it
    task automatic send_word(input req_t word, input rsp_t result);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= word;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_results.push_back(result);
    endtask

    // receiver: random stall, or one long hold-off on request
    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++)
                begin
                    rsp_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word, actual %h / %b",
                         $time, rsp.value_out, rsp.not_finite);
                error_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (rsp.value_out !== oldest_result.value_out)
                begin
                    $display("%0t: value_out mismatch, expected %h actual %h",
                             $time, oldest_result.value_out, rsp.value_out);
                    error_count++;
                end
                if (rsp.not_finite !== oldest_result.not_finite)
                begin
                    $display("%0t: not_finite mismatch, expected %b actual %b",
                             $time, oldest_result.not_finite, rsp.not_finite);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // stimulus
    initial
    begin
        req_t word;
        rsp_t result;
        rst_n        <= 1'b0;
        req_valid    <= 1'b0;
        req          <= '0;
        hold_request <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            word.req_type = directed_vectors[i].op;
            word.value_in = directed_vectors[i].bits;
            if (directed_vectors[i].typed)
            begin
                result.value_out  = directed_vectors[i].typed_out;
                result.not_finite = directed_vectors[i].typed_nf;
            end
            else
                result = convert_word(word);
            send_word(word, result);
        end

        // random words under each idle / stall mix
        for (int m = 0; m < 4; m++)
        begin
            send_idle_pct = mix_idle[m];
            stall_pct     = mix_stall[m];
            repeat (RANDOM_PER_MIX)
            begin
                word = random_word();
                send_word(word, convert_word(word));
            end
        end

        // long receiver hold-off while words keep coming, block backs up
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request <= 1'b1;
        repeat (30)
        begin
            word = random_word();
            send_word(word, convert_word(word));
        end

        // sender pauses until the block has drained
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);

        send_idle_pct = 18;
        stall_pct     = 18;
        repeat (20)
        begin
            word = random_word();
            send_word(word, convert_word(word));
        end
        req_valid <= 1'b0;

        // wait for the last results, then a few quiet cycles
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
